/* rtl/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV record tokenizer: byte codes,
// token kinds, parser phases and the queue entry between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] SEP_RESET = 8'd44;

	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_FIELD   = 2'd1,
		KIND_RECORD  = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_RECORD  = 6'b000001,
		PH_FIELD   = 6'b000010,
		PH_PLAIN   = 6'b000100,
		PH_QUOTED  = 6'b001000,
		PH_AFTERQ  = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	// One accepted byte's worth of tokens: a first token and, when two is
	// set, a trailing record end.
	typedef struct packed {
		logic       two;
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

endpackage

`default_nettype wire

/* rtl/csv_record_tokenizer.sv */
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming CSV tokenizer: bytes in, content/field-end/record-end tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one text byte per transaction in s_tdata, s_tlast set
//   on the final byte of a buffer. Master channel m_*: one token per
//   transaction; m_tuser is the token kind (content, field end, record end,
//   format error), m_tdata the content byte (zero for marks), m_tlast flags
//   the last token caused by an input byte. A byte may cause zero, one or
//   two tokens. cfg_wr_en/cfg_wr_data set the separator byte; write it only
//   while the block is idle.
// Throughput:
//   Tokens pass through the queue between classifier and emitter, then the
//   output register. Input runs at one byte per cycle while s_tready is high;
//   output at one token per cycle while m_tready is high. A byte with two
//   tokens needs an extra output transaction; the QUEUE_DEPTH queue absorbs it.
// Reset and stall:
//   Reset returns the parser to record start, the separator to comma and
//   empties the queue. When m_tready is low a valid output register holds; the
//   queue keeps taking bytes until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_record_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_byte
	input  wire logic       s_tlast,   // final_byte
	output      logic       m_tvalid,
	input  wire logic       m_tready,
	output      logic [7:0] m_tdata,   // [7:0] content_byte
	output      logic [1:0] m_tuser,   // [1:0] token_kind
	output      logic       m_tlast    // run_end
);

	logic             accept;
	logic             push;
	csvt_pkg::entry_t push_entry;
	logic             full;
	logic             pop;
	logic             empty;
	csvt_pkg::entry_t head;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	csvt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept     (accept),
		.text_byte  (s_tdata),
		.final_byte (s_tlast),
		.push       (push),
		.push_entry (push_entry)
	);

	csvt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	csvt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

/* rtl/csvt_front.sv */
// ----------------------------------------------------------------------------
// csvt_front
// Byte classifier: runs the parse phase machine on each accepted byte and
// turns it into at most one queue entry (one or two tokens).
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire logic             accept,
	input  wire logic [7:0]       text_byte,
	input  wire logic             final_byte,
	output      logic             push,
	output      csvt_pkg::entry_t push_entry
);

	logic [7:0]        sep_q;
	csvt_pkg::phase_t  phase_q;
	csvt_pkg::phase_t  phase_nx;
	csvt_pkg::phase_t  phase_step;
	logic              tok_v;
	csvt_pkg::kind_t   tok_kind;
	logic              is_brk;
	logic              is_quote;
	logic              is_sep;
	logic              fin_rec;

	assign is_brk   = (text_byte == csvt_pkg::CH_LF) || (text_byte == csvt_pkg::CH_CR);
	assign is_quote = (text_byte == csvt_pkg::CH_QUOTE);
	assign is_sep   = (text_byte == sep_q);

	// Classify the byte against the current phase
	always_comb begin
		tok_v      = 1'b0;
		tok_kind   = csvt_pkg::KIND_CONTENT;
		phase_step = phase_q;
		case (phase_q)
			csvt_pkg::PH_FIELD: begin
				if (is_quote) begin
					phase_step = csvt_pkg::PH_QUOTED;
				end else if (is_sep) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_FIELD;
					phase_step = csvt_pkg::PH_FIELD;
				end else if (is_brk) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_RECORD;
					phase_step = csvt_pkg::PH_RECORD;
				end else begin
					tok_v      = 1'b1;
					phase_step = csvt_pkg::PH_PLAIN;
				end
			end
			csvt_pkg::PH_PLAIN: begin
				if (is_sep) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_FIELD;
					phase_step = csvt_pkg::PH_FIELD;
				end else if (is_brk) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_RECORD;
					phase_step = csvt_pkg::PH_RECORD;
				end else begin
					tok_v = 1'b1;
				end
			end
			csvt_pkg::PH_QUOTED: begin
				if (is_quote) begin
					phase_step = csvt_pkg::PH_AFTERQ;
				end else begin
					tok_v = 1'b1;
				end
			end
			csvt_pkg::PH_AFTERQ: begin
				if (is_quote) begin
					tok_v      = 1'b1;
					phase_step = csvt_pkg::PH_QUOTED;
				end else if (is_sep) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_FIELD;
					phase_step = csvt_pkg::PH_FIELD;
				end else if (is_brk) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_RECORD;
					phase_step = csvt_pkg::PH_RECORD;
				end else begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_ERROR;
					phase_step = csvt_pkg::PH_DISCARD;
				end
			end
			csvt_pkg::PH_DISCARD: begin
				phase_step = csvt_pkg::PH_DISCARD;
			end
			default: begin
				if (is_brk) begin
					phase_step = csvt_pkg::PH_RECORD;
				end else if (is_quote) begin
					phase_step = csvt_pkg::PH_QUOTED;
				end else if (is_sep) begin
					tok_v      = 1'b1;
					tok_kind   = csvt_pkg::KIND_FIELD;
					phase_step = csvt_pkg::PH_FIELD;
				end else begin
					tok_v      = 1'b1;
					phase_step = csvt_pkg::PH_PLAIN;
				end
			end
		endcase
	end

	// Close an open record on the final byte and return to record start
	assign fin_rec = final_byte && ((phase_step == csvt_pkg::PH_FIELD) ||
		(phase_step == csvt_pkg::PH_PLAIN) || (phase_step == csvt_pkg::PH_QUOTED) ||
		(phase_step == csvt_pkg::PH_AFTERQ));
	assign phase_nx = final_byte ? csvt_pkg::PH_RECORD : phase_step;

	// Build the queue entry
	always_comb begin
		push_entry = '0;
		if (tok_v) begin
			push_entry.kind = tok_kind;
			push_entry.data = (tok_kind == csvt_pkg::KIND_CONTENT) ? text_byte : 8'd0;
			push_entry.two  = fin_rec;
		end else begin
			push_entry.kind = csvt_pkg::KIND_RECORD;
		end
	end
	assign push = accept && (tok_v || fin_rec);

	// Hold separator and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q   <= csvt_pkg::SEP_RESET;
			phase_q <= csvt_pkg::PH_RECORD;
		end else begin
			if (cfg_wr_en) begin
				sep_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q <= phase_nx;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/csvt_queue.sv */
// ----------------------------------------------------------------------------
// csvt_queue
// Short FIFO of token entries between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire csvt_pkg::entry_t push_entry,
	output      logic             full,
	input  wire logic             pop,
	output      logic             empty,
	output      csvt_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	csvt_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Write storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("csvt_queue: push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("csvt_queue: pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("csvt_queue: occupancy beyond depth");

endmodule

`default_nettype wire

/* rtl/csvt_back.sv */
// ----------------------------------------------------------------------------
// csvt_back
// Token emitter: drains queue entries into the output register, one token
// per transaction, splitting two-token entries over two transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire csvt_pkg::entry_t head,
	output      logic             pop,
	output      logic             m_tvalid,
	input  wire logic             m_tready,
	output      logic [7:0]       m_tdata,
	output      logic [1:0]       m_tuser,
	output      logic             m_tlast
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic       m_tlast_q;
	logic       half_q;
	logic       load;

	assign load = !m_tvalid_q || m_tready;
	assign pop  = load && !empty && (half_q || !head.two);

	// Load the output register from the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			half_q     <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= !empty;
			if (!empty) begin
				half_q <= !half_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (half_q) begin
				m_tuser_q <= csvt_pkg::KIND_RECORD;
				m_tdata_q <= 8'd0;
				m_tlast_q <= 1'b1;
			end else begin
				m_tuser_q <= head.kind;
				m_tdata_q <= head.data;
				m_tlast_q <= !head.two;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_half_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (!empty && head.two))
		else $error("csvt_back: second token pending without a pair entry");

	a_second_is_record: assert property (@(posedge clk) disable iff (!arst_n)
		(load && half_q) |=> (m_tvalid_q && m_tlast_q &&
		m_tuser_q == csvt_pkg::KIND_RECORD))
		else $error("csvt_back: second token is not a closing record end");

endmodule

`default_nettype wire
